[design/eight_bit_alu_with_flags_assert.svh]
// Assertion macros for the eight-bit ALU block.
// Used by modules that include this header; depends on clk and rst_n in scope.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ALU8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ALU8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ALU8_ASSERT_NOW(lbl, ante, cons, msg)
`define ALU8_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[design/alu8_pkg.sv]
// Package for the eight-bit ALU: operation codes, flag and item types.
// No dependencies.
`default_nettype none
package alu8_pkg;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_CP   = 5'd4,
    OP_AND  = 5'd5,
    OP_OR   = 5'd6,
    OP_XOR  = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_BIT  = 5'd10,
    OP_RL   = 5'd11,
    OP_RLC  = 5'd12,
    OP_RR   = 5'd13,
    OP_RRC  = 5'd14,
    OP_SLA  = 5'd15,
    OP_SRA  = 5'd16,
    OP_SRL  = 5'd17,
    OP_SWAP = 5'd18,
    OP_ADDI = 5'd19,
    OP_ADDW = 5'd20
  } action_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [4:0]  action;
    logic [15:0] operand;
    logic [15:0] base;
    logic [2:0]  bit_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    flags_t      flags;
  } out_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  acc;
    flags_t      flags;
  } core_out_t;

endpackage
`default_nettype wire

[design/alu8_if.sv]
// Valid/ready channel interfaces for the eight-bit ALU input and result items.
// No dependencies.
`default_nettype none
interface alu8_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  action;
  logic [15:0] operand;
  logic [15:0] base;
  logic [2:0]  bit_index;

  modport source (output valid, output action, output operand, output base,
                  output bit_index, input ready);
  modport sink   (input valid, input action, input operand, input base,
                  input bit_index, output ready);
endinterface

interface alu8_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic        zero_flag;
  logic        negative_flag;
  logic        half_flag;
  logic        carry_flag;

  modport source (output valid, output result, output zero_flag, output negative_flag,
                  output half_flag, output carry_flag, input ready);
  modport sink   (input valid, input result, input zero_flag, input negative_flag,
                  input half_flag, input carry_flag, output ready);
endinterface
`default_nettype wire

[design/alu8_core.sv]
// Combinational ALU datapath: one item plus accumulator and flags in,
// result, next accumulator and next flags out. Depends on alu8_pkg.
`default_nettype none
module alu8_core (
  input  wire alu8_pkg::in_item_t  item,
  input  wire logic [7:0]          acc,
  input  wire alu8_pkg::flags_t    flags,
  output alu8_pkg::core_out_t      res
);

  logic [7:0]  n8;
  logic [7:0]  b8;
  logic        cin;
  logic [8:0]  add9;
  logic [4:0]  addh;
  logic [8:0]  sub9;
  logic [4:0]  subh;
  logic [7:0]  ires;
  logic [16:0] sumw;
  logic [12:0] sumh12;
  logic [8:0]  sumi8;
  logic [4:0]  sumi4;
  logic [15:0] ext;
  logic [7:0]  sh;
  logic        sh_c;

  assign n8  = item.operand[7:0];
  assign b8  = item.base[7:0];
  assign cin = ((item.action == alu8_pkg::OP_ADC) || (item.action == alu8_pkg::OP_SBC))
               ? flags.c : 1'b0;

  assign add9 = {1'b0, acc} + {1'b0, n8} + {8'd0, cin};
  assign addh = {1'b0, acc[3:0]} + {1'b0, n8[3:0]} + {4'd0, cin};
  assign sub9 = {1'b0, acc} - {1'b0, n8} - {8'd0, cin};
  assign subh = {1'b0, acc[3:0]} - {1'b0, n8[3:0]} - {4'd0, cin};

  assign ext    = {{8{n8[7]}}, n8};
  assign sumi8  = {1'b0, item.base[7:0]} + {1'b0, n8};
  assign sumi4  = {1'b0, item.base[3:0]} + {1'b0, n8[3:0]};
  assign sumw   = {1'b0, item.base} + {1'b0, item.operand};
  assign sumh12 = {1'b0, item.base[11:0]} + {1'b0, item.operand[11:0]};

  // rotate and shift unit
  always_comb begin
    sh   = b8;
    sh_c = b8[0];
    case (item.action)
      alu8_pkg::OP_RL: begin
        sh   = {b8[6:0], flags.c};
        sh_c = b8[7];
      end
      alu8_pkg::OP_RLC: begin
        sh   = {b8[6:0], b8[7]};
        sh_c = b8[7];
      end
      alu8_pkg::OP_RR: begin
        sh   = {flags.c, b8[7:1]};
        sh_c = b8[0];
      end
      alu8_pkg::OP_RRC: begin
        sh   = {b8[0], b8[7:1]};
        sh_c = b8[0];
      end
      alu8_pkg::OP_SLA: begin
        sh   = {b8[6:0], 1'b0};
        sh_c = b8[7];
      end
      alu8_pkg::OP_SRA: begin
        sh   = {b8[7], b8[7:1]};
        sh_c = b8[0];
      end
      alu8_pkg::OP_SRL: begin
        sh   = {1'b0, b8[7:1]};
        sh_c = b8[0];
      end
      default: begin
        sh   = b8;
        sh_c = b8[0];
      end
    endcase
  end

  always_comb begin
    res.acc    = acc;
    res.flags  = flags;
    res.result = {8'd0, acc};
    ires       = 8'd0;
    case (item.action)
      alu8_pkg::OP_ADD, alu8_pkg::OP_ADC: begin
        res.acc    = add9[7:0];
        res.flags  = '{z: (add9[7:0] == 8'd0), n: 1'b0, h: addh[4], c: add9[8]};
        res.result = {8'd0, add9[7:0]};
      end
      alu8_pkg::OP_SUB, alu8_pkg::OP_SBC: begin
        res.acc    = sub9[7:0];
        res.flags  = '{z: (sub9[7:0] == 8'd0), n: 1'b1, h: subh[4], c: sub9[8]};
        res.result = {8'd0, sub9[7:0]};
      end
      alu8_pkg::OP_CP: begin
        res.flags  = '{z: (sub9[7:0] == 8'd0), n: 1'b1, h: subh[4], c: sub9[8]};
      end
      alu8_pkg::OP_AND: begin
        ires       = acc & n8;
        res.acc    = ires;
        res.flags  = '{z: (ires == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
        res.result = {8'd0, ires};
      end
      alu8_pkg::OP_OR: begin
        ires       = acc | n8;
        res.acc    = ires;
        res.flags  = '{z: (ires == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        res.result = {8'd0, ires};
      end
      alu8_pkg::OP_XOR: begin
        ires       = acc ^ n8;
        res.acc    = ires;
        res.flags  = '{z: (ires == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        res.result = {8'd0, ires};
      end
      alu8_pkg::OP_INC: begin
        ires       = b8 + 8'd1;
        res.flags  = '{z: (ires == 8'd0), n: 1'b0, h: (b8[3:0] == 4'hf), c: flags.c};
        res.result = {8'd0, ires};
      end
      alu8_pkg::OP_DEC: begin
        ires       = b8 - 8'd1;
        res.flags  = '{z: (ires == 8'd0), n: 1'b1, h: (b8[3:0] == 4'h0), c: flags.c};
        res.result = {8'd0, ires};
      end
      alu8_pkg::OP_BIT: begin
        res.flags  = '{z: !b8[item.bit_index], n: 1'b0, h: 1'b1, c: flags.c};
        res.result = 16'd0;
      end
      alu8_pkg::OP_RL, alu8_pkg::OP_RLC, alu8_pkg::OP_RR, alu8_pkg::OP_RRC,
      alu8_pkg::OP_SLA, alu8_pkg::OP_SRA, alu8_pkg::OP_SRL: begin
        res.flags  = '{z: (sh == 8'd0), n: 1'b0, h: 1'b0, c: sh_c};
        res.result = {8'd0, sh};
      end
      alu8_pkg::OP_SWAP: begin
        ires       = {b8[3:0], b8[7:4]};
        res.flags  = '{z: (ires == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
        res.result = {8'd0, ires};
      end
      alu8_pkg::OP_ADDI: begin
        res.flags  = '{z: 1'b0, n: 1'b0, h: sumi4[4], c: sumi8[8]};
        res.result = item.base + ext;
      end
      alu8_pkg::OP_ADDW: begin
        res.flags  = '{z: flags.z, n: 1'b0, h: sumh12[12], c: sumw[16]};
        res.result = sumw[15:0];
      end
      default: begin
        res.acc    = acc;
        res.flags  = flags;
        res.result = {8'd0, acc};
      end
    endcase
  end

endmodule
`default_nettype wire

[design/eight_bit_alu_with_flags.sv]
// Eight-bit ALU with accumulator and Z/N/H/C flags.
// Items enter on in_ch (valid/ready) and results leave on out_ch (valid/ready).
// Each input item names an operation (add..xor on the accumulator, inc, dec,
// bit test, rotates, shifts, swap, and the 16-bit adds addi and addw) and
// yields exactly one result item: the value plus all four flags afterwards.
// An accepted item lands in the input register, then passes the
// combinational datapath in alu8_core into the result register, which
// drives out_ch.
// Throughput: one item per cycle while out_ch.ready is high; the accumulator
// and flags update when an item moves from the input register to the result
// register, so each item sees the state left by the one before it.
// Reset (rst_n low, synchronous) empties both registers and clears the
// accumulator and flags.
// When out_ch.ready is low, the result register holds; one more item may sit
// in the input register, after which in_ch.ready drops until the result is taken.
`default_nettype none
`include "eight_bit_alu_with_flags_assert.svh"
module eight_bit_alu_with_flags (
  input  wire logic   clk,
  input  wire logic   rst_n,
  alu8_in_if.sink     in_ch,
  alu8_out_if.source  out_ch
);

  logic                 s1_v_r;
  alu8_pkg::in_item_t   s1_item_r;
  logic                 out_v_r;
  alu8_pkg::out_item_t  out_r;
  logic [7:0]           acc_r;
  alu8_pkg::flags_t     flags_r;
  alu8_pkg::core_out_t  core_nxt;
  logic                 adv;
  logic                 in_rdy;
  logic                 in_fire;

  assign adv     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_rdy  = !s1_v_r || adv;
  assign in_fire = in_ch.valid && in_rdy;

  assign in_ch.ready          = in_rdy;
  assign out_ch.valid         = out_v_r;
  assign out_ch.result        = out_r.result;
  assign out_ch.zero_flag     = out_r.flags.z;
  assign out_ch.negative_flag = out_r.flags.n;
  assign out_ch.half_flag     = out_r.flags.h;
  assign out_ch.carry_flag    = out_r.flags.c;

  alu8_core u_core (
    .item  (s1_item_r),
    .acc   (acc_r),
    .flags (flags_r),
    .res   (core_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      acc_r   <= 8'd0;
      flags_r <= '0;
    end else begin
      if (in_rdy) begin
        s1_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        acc_r   <= core_nxt.acc;
        flags_r <= core_nxt.flags;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{action: in_ch.action, operand: in_ch.operand,
                     base: in_ch.base, bit_index: in_ch.bit_index};
    end
    if (adv) begin
      out_r <= '{result: core_nxt.result, flags: core_nxt.flags};
    end
  end

  `ALU8_ASSERT_NOW(a_stall_only_when_full, !in_rdy, s1_v_r && out_v_r && !out_ch.ready, "input stalled while a register is free")
  `ALU8_ASSERT_NEXT(a_flags_match_out, adv, out_r.flags == flags_r, "reported flags differ from flag register")
  `ALU8_ASSERT_NEXT(a_cp_keeps_acc, adv && (s1_item_r.action == alu8_pkg::OP_CP), acc_r == $past(acc_r), "cp changed the accumulator")
  `ALU8_ASSERT_NEXT(a_keep_carry, adv && ((s1_item_r.action == alu8_pkg::OP_INC) || (s1_item_r.action == alu8_pkg::OP_DEC) || (s1_item_r.action == alu8_pkg::OP_BIT)), flags_r.c == $past(flags_r.c), "inc, dec or bit changed carry")
  `ALU8_ASSERT_NEXT(a_byte_result, adv && (s1_item_r.action != alu8_pkg::OP_ADDI) && (s1_item_r.action != alu8_pkg::OP_ADDW), out_r.result[15:8] == 8'd0, "eight-bit result not zero extended")

endmodule
`default_nettype wire

[test/eight_bit_alu_with_flags_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the eight-bit ALU: watches both channels, predicts each result.
// Depends on alu8_pkg and the alu8_in_if / alu8_out_if interfaces.
module eight_bit_alu_with_flags_checker
  import alu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  alu8_in_if          in_mon,
  alu8_out_if         out_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_count,
  output int unsigned checked_count
);

  logic [7:0] acc_now;
  flags_t     flags_now;
  out_item_t  alu_outcomes_q[$];

  // Executes one op against the shadow accumulator and flags.
  function automatic out_item_t compute_alu_op(in_item_t it);
    logic [7:0]  a, opb, b, r8;
    logic [8:0]  s9;
    logic [4:0]  nib;
    logic [12:0] s13;
    logic [16:0] s17;
    logic        ci, cout;
    flags_t      f;
    out_item_t   o;
    a        = acc_now;
    opb      = it.operand[7:0];
    b        = it.base[7:0];
    ci       = 1'b0;
    cout     = 1'b0;
    r8       = 8'h00;
    f        = flags_now;
    o.result = {8'h00, acc_now};
    case (it.action)
      OP_ADD, OP_ADC: begin
        if (it.action == OP_ADC) ci = flags_now.c;
        s9       = {1'b0, a} + {1'b0, opb} + {8'h00, ci};
        nib      = {1'b0, a[3:0]} + {1'b0, opb[3:0]} + {4'h0, ci};
        f        = {s9[7:0] == 8'h00, 1'b0, nib[4], s9[8]};
        acc_now  = s9[7:0];
        o.result = {8'h00, s9[7:0]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        if (it.action == OP_SBC) ci = flags_now.c;
        s9  = {1'b0, a} - {1'b0, opb} - {8'h00, ci};
        nib = {1'b0, a[3:0]} - {1'b0, opb[3:0]} - {4'h0, ci};
        f   = {s9[7:0] == 8'h00, 1'b1, nib[4], s9[8]};
        if (it.action != OP_CP) begin
          acc_now  = s9[7:0];
          o.result = {8'h00, s9[7:0]};
        end
      end
      OP_AND, OP_OR, OP_XOR: begin
        case (it.action)
          OP_AND:  r8 = a & opb;
          OP_OR:   r8 = a | opb;
          default: r8 = a ^ opb;
        endcase
        f        = {r8 == 8'h00, 1'b0, it.action == OP_AND, 1'b0};
        acc_now  = r8;
        o.result = {8'h00, r8};
      end
      OP_INC: begin
        r8       = b + 8'd1;
        f        = {r8 == 8'h00, 1'b0, b[3:0] == 4'hf, flags_now.c};
        o.result = {8'h00, r8};
      end
      OP_DEC: begin
        r8       = b - 8'd1;
        f        = {r8 == 8'h00, 1'b1, b[3:0] == 4'h0, flags_now.c};
        o.result = {8'h00, r8};
      end
      OP_BIT: begin
        f        = {~b[it.bit_index], 1'b0, 1'b1, flags_now.c};
        o.result = 16'h0000;
      end
      OP_RL, OP_RLC, OP_RR, OP_RRC, OP_SLA, OP_SRA, OP_SRL: begin
        case (it.action)
          OP_RL:   begin r8 = {b[6:0], flags_now.c}; cout = b[7]; end
          OP_RLC:  begin r8 = {b[6:0], b[7]};        cout = b[7]; end
          OP_RR:   begin r8 = {flags_now.c, b[7:1]}; cout = b[0]; end
          OP_RRC:  begin r8 = {b[0], b[7:1]};        cout = b[0]; end
          OP_SLA:  begin r8 = {b[6:0], 1'b0};        cout = b[7]; end
          OP_SRA:  begin r8 = {b[7], b[7:1]};        cout = b[0]; end
          default: begin r8 = {1'b0, b[7:1]};        cout = b[0]; end
        endcase
        f        = {r8 == 8'h00, 1'b0, 1'b0, cout};
        o.result = {8'h00, r8};
      end
      OP_SWAP: begin
        r8       = {b[3:0], b[7:4]};
        f        = {r8 == 8'h00, 3'b000};
        o.result = {8'h00, r8};
      end
      OP_ADDI: begin
        nib      = {1'b0, it.base[3:0]} + {1'b0, opb[3:0]};
        s9       = {1'b0, it.base[7:0]} + {1'b0, opb};
        f        = {1'b0, 1'b0, nib[4], s9[8]};
        o.result = it.base + {{8{opb[7]}}, opb};
      end
      OP_ADDW: begin
        s13      = {1'b0, it.base[11:0]} + {1'b0, it.operand[11:0]};
        s17      = {1'b0, it.base} + {1'b0, it.operand};
        f        = {flags_now.z, 1'b0, s13[12], s17[16]};
        o.result = s17[15:0];
      end
      default: ;
    endcase
    flags_now = f;
    o.flags   = f;
    return o;
  endfunction

  always @(posedge clk) begin : scoreboard
    out_item_t want;
    in_item_t  it;
    if (!rst_n) begin
      acc_now        = 8'h00;
      flags_now      = '0;
      mismatch_count = 0;
      checked_count  = 0;
      alu_outcomes_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (alu_outcomes_q.size() == 0) begin
          $error("result item with nothing expected: result %h", out_mon.result);
          mismatch_count++;
        end else begin
          want = alu_outcomes_q.pop_front();
          checked_count++;
          if (out_mon.result !== want.result) begin
            $error("result: expected %h, got %h", want.result, out_mon.result);
            mismatch_count++;
          end
          if (out_mon.zero_flag !== want.flags.z) begin
            $error("zero_flag: expected %b, got %b", want.flags.z, out_mon.zero_flag);
            mismatch_count++;
          end
          if (out_mon.negative_flag !== want.flags.n) begin
            $error("negative_flag: expected %b, got %b", want.flags.n,
                   out_mon.negative_flag);
            mismatch_count++;
          end
          if (out_mon.half_flag !== want.flags.h) begin
            $error("half_flag: expected %b, got %b", want.flags.h, out_mon.half_flag);
            mismatch_count++;
          end
          if (out_mon.carry_flag !== want.flags.c) begin
            $error("carry_flag: expected %b, got %b", want.flags.c, out_mon.carry_flag);
            mismatch_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it.action    = in_mon.action;
        it.operand   = in_mon.operand;
        it.base      = in_mon.base;
        it.bit_index = in_mon.bit_index;
        alu_outcomes_q.push_back(compute_alu_op(it));
      end
    end
    pending_count = alu_outcomes_q.size();
  end

endmodule

[test/eight_bit_alu_with_flags_tb.sv]
`timescale 1ns / 100ps
// Top of the eight-bit ALU testbench: clock, reset, item traffic and verdict.
// Depends on alu8_pkg, the alu8 interfaces, the DUT and the scoreboard module.
module eight_bit_alu_with_flags_tb;
  import alu8_pkg::*;

  localparam int unsigned HOLD_CYCLES = 60;
  localparam logic [4:0]  ACT_UNUSED_LO = 5'd21;
  localparam logic [4:0]  ACT_UNUSED_HI = 5'd31;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        gaps_on = 1'b1;
  logic        hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned alu_mismatches, outstanding, results_checked;

  alu8_in_if  in_ch ();
  alu8_out_if out_ch ();

  eight_bit_alu_with_flags DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  eight_bit_alu_with_flags_checker scoreboard_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (alu_mismatches),
    .pending_count  (outstanding),
    .checked_count  (results_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_500_000;
    $display("eight_bit_alu_with_flags_tb NOT OK");
    $finish;
  end

  // result side: random stalls, one long hold on request
  initial begin : result_sink
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic offer_op(input logic [4:0] act, input logic [15:0] opnd,
                          input logic [15:0] base_w, input logic [2:0] idx);
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.operand   <= opnd;
    in_ch.base      <= base_w;
    in_ch.bit_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h00ff;
      3:       return 16'h0fff;
      4:       return 16'h0f0f;
      5:       return 16'h8080;
      6:       return 16'({$urandom_range(0, 255)});
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic offer_random_op();
    logic [4:0] act;
    if ($urandom_range(0, 15) == 0)
      act = 5'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    else
      act = 5'($urandom_range(OP_ADD, OP_ADDW));
    offer_op(act, pick_word(), pick_word(), 3'($urandom_range(0, 7)));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 5000 && outstanding != 0; k++) @(posedge clk);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= OP_ADD;
    in_ch.operand   <= 16'h0000;
    in_ch.base      <= 16'h0000;
    in_ch.bit_index <= 3'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: carries, borrows, zero results, every op, unused codes
    offer_op(OP_ADD,  16'h0000, 16'h0000, 3'd0);
    offer_op(OP_ADD,  16'hffff, 16'h0000, 3'd0);
    offer_op(OP_ADD,  16'h0001, 16'h0000, 3'd0);
    offer_op(OP_ADC,  16'h00ff, 16'h0000, 3'd0);
    offer_op(OP_SBC,  16'h0000, 16'h0000, 3'd0);
    offer_op(OP_SUB,  16'h00ff, 16'h0000, 3'd0);
    offer_op(OP_CP,   16'h0001, 16'h0000, 3'd0);
    offer_op(OP_OR,   16'hff00, 16'h0000, 3'd0);
    offer_op(OP_OR,   16'h00ff, 16'h0000, 3'd0);
    offer_op(OP_AND,  16'h000f, 16'h0000, 3'd0);
    offer_op(OP_XOR,  16'h000f, 16'h0000, 3'd0);
    offer_op(OP_INC,  16'h0000, 16'hffff, 3'd0);
    offer_op(OP_DEC,  16'h0000, 16'h0000, 3'd0);
    offer_op(OP_BIT,  16'h0000, 16'h0080, 3'd7);
    offer_op(OP_BIT,  16'h0000, 16'hfffe, 3'd0);
    offer_op(OP_RL,   16'h0000, 16'h0080, 3'd0);
    offer_op(OP_RLC,  16'h0000, 16'h0080, 3'd0);
    offer_op(OP_RR,   16'h0000, 16'h0001, 3'd0);
    offer_op(OP_RRC,  16'h0000, 16'h0001, 3'd0);
    offer_op(OP_SLA,  16'h0000, 16'hffff, 3'd0);
    offer_op(OP_SRA,  16'h0000, 16'h0081, 3'd0);
    offer_op(OP_SRL,  16'h0000, 16'h0001, 3'd0);
    offer_op(OP_SWAP, 16'h0000, 16'h00f0, 3'd0);
    offer_op(OP_ADDI, 16'h0001, 16'hffff, 3'd0);
    offer_op(OP_ADDI, 16'hff80, 16'h0000, 3'd0);
    offer_op(OP_ADDW, 16'h0001, 16'hffff, 3'd0);
    offer_op(OP_ADDW, 16'h0001, 16'h0fff, 3'd0);
    offer_op(ACT_UNUSED_HI, 16'hffff, 16'hffff, 3'd7);
    offer_op(ACT_UNUSED_LO, 16'h0000, 16'h0000, 3'd0);

    repeat (600) offer_random_op();

    // pause until every result is back, then fill the block behind a long stall
    drain_results();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (60) offer_random_op();
    gaps_on = 1'b1;

    repeat (840) offer_random_op();

    // last stretch runs without idling
    gaps_on = 1'b0;
    repeat (350) offer_random_op();

    drain_results();
    repeat (8) @(posedge clk);
    if (outstanding != 0) $error("%0d results never arrived", outstanding);
    $display("sent %0d items over all operations and unused codes, with random stalls,",
             items_sent);
    $display("a %0d-cycle output hold and a drain pause; %0d results compared",
             HOLD_CYCLES, results_checked);
    if (alu_mismatches == 0 && outstanding == 0) begin
      $display("eight_bit_alu_with_flags_tb OK");
    end else begin
      $display("eight_bit_alu_with_flags_tb NOT OK");
    end
    $finish;
  end

endmodule
